@@ hdl/mlpfr_pkg.sv @@
`timescale 1ns / 1ps
package mlpfr_pkg;

  localparam int InputCountDef  = 256;
  localparam int MaxNeuronsDef  = 64;
  localparam int MaxLayersDef   = 4;
  localparam int WeightDepthDef = 32768;

  localparam int WidthRegs = 4;
  localparam int TanhSegs  = 24;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_WIDTH0      = 3'd1,
    REG_WIDTH1      = 3'd2,
    REG_WIDTH2      = 3'd3,
    REG_WIDTH3      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_BIAS,
    ST_ACT,
    ST_TANH,
    ST_DONE
  } state_t;

  // tanh(k/4) scaled by 16384, rounded to nearest.
  function automatic logic [14:0] tanh_point(input logic [4:0] k);
    logic [14:0] t;
    case (k)
      5'd0:  t = 15'd0;
      5'd1:  t = 15'd4013;
      5'd2:  t = 15'd7571;
      5'd3:  t = 15'd10406;
      5'd4:  t = 15'd12478;
      5'd5:  t = 15'd13898;
      5'd6:  t = 15'd14830;
      5'd7:  t = 15'd15424;
      5'd8:  t = 15'd15795;
      5'd9:  t = 15'd16024;
      5'd10: t = 15'd16165;
      5'd11: t = 15'd16250;
      5'd12: t = 15'd16303;
      5'd13: t = 15'd16335;
      5'd14: t = 15'd16354;
      5'd15: t = 15'd16366;
      5'd16: t = 15'd16373;
      5'd17: t = 15'd16377;
      5'd18: t = 15'd16380;
      5'd19: t = 15'd16382;
      5'd20: t = 15'd16383;
      5'd21: t = 15'd16383;
      5'd22: t = 15'd16383;
      default: t = 15'd16384;
    endcase
    return t;
  endfunction

endpackage

@@ hdl/mlpfr_if.sv @@
`timescale 1ns / 1ps
interface mlpfr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [14:0]        address;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, op, address, value, last, input ready);
  modport sink (input valid, op, address, value, last, output ready);
endinterface

interface mlpfr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;

  modport source (output valid, score, input ready);
  modport sink (input valid, score, output ready);
endinterface

@@ hdl/mlp_forward_relu_tanh_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_beat   in   valid/ready    op, address, value, last
// out_beat  out  valid/ready    score
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// A weight, bias or plain input beat is stored when accepted; while idle, beats can
// follow back to back. An input beat with last set runs the network on one shared
// multiply-accumulate pipe, neuron by neuron: its terms (INPUT_COUNT, then the
// previous layer width), bias, ReLU; tanh follows. Each memory has one read port.
// Reset (synchronous, active low) clears control state only; memories stay undefined.
// Input is ready only when idle; a score waits in the output register until taken.
module mlp_forward_relu_tanh_core
  import mlpfr_pkg::*;
#(
  parameter int INPUT_COUNT  = InputCountDef,
  parameter int MAX_NEURONS  = MaxNeuronsDef,
  parameter int MAX_LAYERS   = MaxLayersDef,
  parameter int WEIGHT_DEPTH = WeightDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  mlpfr_in_if.sink           in_beat,
  mlpfr_out_if.source        out_beat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);

  localparam int WAW  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int IAW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int NIW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int BD   = MAX_LAYERS * MAX_NEURONS;
  localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int AD   = 2 * MAX_NEURONS;
  localparam int AAW  = $clog2(AD);
  localparam int NW   = $clog2(MAX_NEURONS + 1);
  localparam int JMAX = (INPUT_COUNT > MAX_NEURONS) ? INPUT_COUNT : MAX_NEURONS;
  localparam int JW   = $clog2(JMAX + 1);
  localparam int MAXL = (MAX_LAYERS < WidthRegs) ? MAX_LAYERS : WidthRegs;
  // Strides through the weight store, already reduced by its depth.
  localparam int ROW_STEP   = MAX_NEURONS % WEIGHT_DEPTH;
  localparam int FIRST_BASE = (MAX_NEURONS * INPUT_COUNT) % WEIGHT_DEPTH;
  localparam int LAYER_STEP = (MAX_NEURONS * MAX_NEURONS) % WEIGHT_DEPTH;

  localparam logic signed [39:0] ACC_HIGH = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_LOW  = {1'b1, {39{1'b0}}};

  // Memories.
  logic signed [15:0] weight_mem [WEIGHT_DEPTH];
  logic signed [15:0] bias_mem [BD];
  logic signed [15:0] input_mem [INPUT_COUNT];
  logic signed [15:0] act_mem [AD];

  state_t             state_r, state_nxt;
  logic [2:0]         layer_count_r;
  logic [6:0]         width_r [WidthRegs];

  logic [2:0]         layer_r, layer_nxt;
  logic [NIW-1:0]     nrn_r, nrn_nxt;
  logic [JW-1:0]      term_r, term_nxt;
  logic [NW-1:0]      prev_w_r, prev_w_nxt;
  logic               bank_r, bank_nxt;
  logic [WAW-1:0]     wptr_r, wptr_nxt;
  logic [WAW-1:0]     row_base_r, row_base_nxt;
  logic [WAW-1:0]     layer_base_r, layer_base_nxt;
  logic [BAW-1:0]     bias_base_r, bias_base_nxt;
  logic               v1_r, v1_nxt;
  logic               v2_r;
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [31:0] prod_r;
  logic signed [15:0] w_q, x_in_q, x_act_q, bias_q;
  logic [14:0]        final_x_r, final_x_nxt;
  logic               big_r;
  logic [14:0]        t0_r;
  logic [14:0]        d_r;
  logic [5:0]         frac_r;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] score_r, score_nxt;

  // Read and write strobes toward the memories.
  logic               act_we;
  logic [AAW-1:0]     act_waddr, act_raddr;
  logic [15:0]        act_wdata;
  logic [BAW-1:0]     bias_raddr;
  logic               bias_rd;

  logic               in_acc;
  logic [2:0]         layers_eff;
  logic [6:0]         width_raw;
  logic [NW-1:0]      width_cur;
  logic [JW-1:0]      term_cnt;
  logic               last_term, last_nrn, last_layer;
  logic signed [40:0] mac_sum, bias_sum;
  logic signed [39:0] bias_term, y_full;
  logic [14:0]        relu_y;
  logic [8:0]         seg;
  logic [4:0]         seg_lo;
  logic [14:0]        tpt0, tpt1;
  logic [20:0]        interp;
  logic [WAW:0]       row_sum, layer_sum;

  assign in_acc         = in_beat.valid && in_beat.ready;
  assign in_beat.ready  = (state_r == ST_IDLE);
  assign out_beat.valid = out_valid_r;
  assign out_beat.score = score_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= 3'd1;
      for (int k = 0; k < WidthRegs; k++) begin
        width_r[k] <= 7'd1;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_COUNT: layer_count_r <= cfg_wdata[2:0];
        REG_WIDTH0:      width_r[0] <= cfg_wdata;
        REG_WIDTH1:      width_r[1] <= cfg_wdata;
        REG_WIDTH2:      width_r[2] <= cfg_wdata;
        REG_WIDTH3:      width_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Memory ports: writes from input beats or activations, registered reads.
  always_ff @(posedge clk) begin
    if (in_acc && (in_beat.op == OP_WEIGHT) && (32'(in_beat.address) < WEIGHT_DEPTH)) begin
      weight_mem[WAW'(in_beat.address)] <= in_beat.value;
    end
    w_q <= weight_mem[wptr_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_beat.op == OP_BIAS) && (32'(in_beat.address) < BD)) begin
      bias_mem[BAW'(in_beat.address)] <= in_beat.value;
    end
    if (bias_rd) begin
      bias_q <= bias_mem[bias_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_beat.op == OP_INPUT) && (32'(in_beat.address) < INPUT_COUNT)) begin
      input_mem[IAW'(in_beat.address)] <= in_beat.value;
    end
    x_in_q <= input_mem[term_r[IAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    x_act_q <= act_mem[act_raddr];
  end

  // Effective layer count and the width of the layer under way.
  always_comb begin
    if (layer_count_r == 3'd0) begin
      layers_eff = 3'd1;
    end else if (layer_count_r > 3'(MAXL)) begin
      layers_eff = 3'(MAXL);
    end else begin
      layers_eff = layer_count_r;
    end
    if (layer_r >= 3'(WidthRegs - 1)) begin
      width_raw = width_r[WidthRegs - 1];
    end else begin
      width_raw = width_r[layer_r[1:0]];
    end
    if (width_raw == 7'd0) begin
      width_cur = NW'(1);
    end else if (9'(width_raw) > 9'(MAX_NEURONS)) begin
      width_cur = NW'(MAX_NEURONS);
    end else begin
      width_cur = NW'(width_raw);
    end
  end

  assign term_cnt   = (layer_r == 3'd0) ? JW'(INPUT_COUNT) : JW'(prev_w_r);
  assign last_term  = (term_r == term_cnt - JW'(1));
  assign last_nrn   = (NW'(nrn_r) == width_cur - NW'(1));
  assign last_layer = (layer_r == layers_eff - 3'd1);

  assign act_raddr  = bank_r ? (AAW'(MAX_NEURONS) + AAW'(term_r[NIW-1:0]))
                             : AAW'(term_r[NIW-1:0]);
  assign act_waddr  = bank_r ? AAW'(nrn_r) : (AAW'(MAX_NEURONS) + AAW'(nrn_r));
  assign bias_raddr = bias_base_r + BAW'(nrn_r);
  assign bias_rd    = (state_r == ST_MAC) && last_term;

  assign row_sum   = {1'b0, row_base_r} + (WAW + 1)'(ROW_STEP);
  assign layer_sum = {1'b0, layer_base_r} + (WAW + 1)'(LAYER_STEP);

  // Accumulator adds, saturating at 40 bits.
  assign mac_sum   = 41'(acc_r) + 41'(prod_r);
  assign bias_term = (layer_r == 3'd0) ? 40'(bias_q) : (40'(bias_q) <<< 8);
  assign bias_sum  = 41'(acc_r) + 41'(bias_term);

  // Neuron output: rescale later layers by a floor shift, clamp, ReLU.
  always_comb begin
    y_full = (layer_r == 3'd0) ? acc_r : (acc_r >>> 8);
    if (y_full < 40'sd0) begin
      relu_y = 15'd0;
    end else if (y_full > 40'sd32767) begin
      relu_y = 15'h7FFF;
    end else begin
      relu_y = y_full[14:0];
    end
  end
  assign act_wdata = {1'b0, relu_y};

  // Tanh table lookup and interpolation.
  assign seg    = final_x_r[14:6];
  assign seg_lo = seg[4:0];
  assign tpt0   = tanh_point(seg_lo);
  assign tpt1   = tanh_point(seg_lo + 5'd1);
  assign interp = 21'(d_r) * 21'(frac_r) + 21'd32;

  always_comb begin
    state_nxt      = state_r;
    layer_nxt      = layer_r;
    nrn_nxt        = nrn_r;
    term_nxt       = term_r;
    prev_w_nxt     = prev_w_r;
    bank_nxt       = bank_r;
    wptr_nxt       = wptr_r;
    row_base_nxt   = row_base_r;
    layer_base_nxt = layer_base_r;
    bias_base_nxt  = bias_base_r;
    v1_nxt         = 1'b0;
    acc_nxt        = acc_r;
    final_x_nxt    = final_x_r;
    act_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_beat.ready;
    score_nxt      = score_r;

    if (v2_r) begin
      if (mac_sum > 41'(ACC_HIGH)) begin
        acc_nxt = ACC_HIGH;
      end else if (mac_sum < 41'(ACC_LOW)) begin
        acc_nxt = ACC_LOW;
      end else begin
        acc_nxt = mac_sum[39:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_beat.op == OP_INPUT) && in_beat.last) begin
          state_nxt      = ST_MAC;
          layer_nxt      = 3'd0;
          nrn_nxt        = '0;
          term_nxt       = '0;
          bank_nxt       = 1'b0;
          wptr_nxt       = '0;
          row_base_nxt   = '0;
          layer_base_nxt = '0;
          bias_base_nxt  = '0;
          acc_nxt        = '0;
        end
      end
      ST_MAC: begin
        v1_nxt   = 1'b1;
        term_nxt = term_r + JW'(1);
        wptr_nxt = (wptr_r == WAW'(WEIGHT_DEPTH - 1)) ? '0 : wptr_r + WAW'(1);
        if (last_term) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: begin
        if (bias_sum > 41'(ACC_HIGH)) begin
          acc_nxt = ACC_HIGH;
        end else if (bias_sum < 41'(ACC_LOW)) begin
          acc_nxt = ACC_LOW;
        end else begin
          acc_nxt = bias_sum[39:0];
        end
        state_nxt = ST_ACT;
      end
      ST_ACT: begin
        act_we   = 1'b1;
        acc_nxt  = '0;
        term_nxt = '0;
        if (last_layer && (nrn_r == '0)) begin
          final_x_nxt = relu_y;
        end
        if (!last_nrn) begin
          nrn_nxt   = nrn_r + NIW'(1);
          state_nxt = ST_MAC;
          // The first layer reads its weights in one continuous run.
          if (layer_r != 3'd0) begin
            row_base_nxt = (row_sum >= (WAW + 1)'(WEIGHT_DEPTH))
                         ? WAW'(row_sum - (WAW + 1)'(WEIGHT_DEPTH)) : WAW'(row_sum);
            wptr_nxt     = row_base_nxt;
          end
        end else if (last_layer) begin
          state_nxt = ST_TANH;
        end else begin
          state_nxt     = ST_MAC;
          layer_nxt     = layer_r + 3'd1;
          nrn_nxt       = '0;
          prev_w_nxt    = width_cur;
          bank_nxt      = !bank_r;
          bias_base_nxt = bias_base_r + BAW'(MAX_NEURONS);
          if (layer_r == 3'd0) begin
            layer_base_nxt = WAW'(FIRST_BASE);
          end else begin
            layer_base_nxt = (layer_sum >= (WAW + 1)'(WEIGHT_DEPTH))
                           ? WAW'(layer_sum - (WAW + 1)'(WEIGHT_DEPTH)) : WAW'(layer_sum);
          end
          row_base_nxt = layer_base_nxt;
          wptr_nxt     = layer_base_nxt;
        end
      end
      ST_TANH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_beat.ready) begin
          out_valid_nxt = 1'b1;
          score_nxt     = big_r ? 16'sd16384 : 16'(t0_r + 15'(interp[20:6]));
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    layer_r      <= layer_nxt;
    nrn_r        <= nrn_nxt;
    term_r       <= term_nxt;
    prev_w_r     <= prev_w_nxt;
    bank_r       <= bank_nxt;
    wptr_r       <= wptr_nxt;
    row_base_r   <= row_base_nxt;
    layer_base_r <= layer_base_nxt;
    bias_base_r  <= bias_base_nxt;
    final_x_r    <= final_x_nxt;
    score_r      <= score_nxt;
    prod_r       <= ((layer_r == 3'd0) ? x_in_q : x_act_q) * w_q;
    big_r        <= (seg >= 9'(TanhSegs));
    t0_r         <= tpt0;
    d_r          <= tpt1 - tpt0;
    frac_r       <= final_x_r[5:0];
  end

`ifndef SYNTH
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("accumulate without a preceding operand read");

  a_score_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("score raised outside the final step");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_beat.op == OP_INPUT) && in_beat.last) |=> (state_r == ST_MAC && acc_r == '0))
    else $error("evaluation did not start from a clear accumulator");

  a_bias_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIAS) |-> (!v1_r && !v2_r))
    else $error("bias added while products still in flight");
`endif

endmodule

@@ test/tb_mlp_forward_relu_tanh_core.sv @@
`timescale 1ns / 1ps
module tb_mlp_forward_relu_tanh_core;
  import mlpfr_pkg::*;

  // Block geometry, matching the defaults of the design.
  localparam int NumInputs   = 256;
  localparam int NumNeurons  = 64;
  localparam int NumLayers   = 4;
  localparam int NumWeights  = 32768;
  localparam int NumBiases   = NumLayers * NumNeurons;
  localparam int HiddenBase  = NumNeurons * NumInputs;
  localparam int RandomBeats = 700;

  // Register indexes that lie past the last defined register.
  localparam logic [2:0] RegFirstUnused = 3'd5;
  localparam logic [2:0] RegUnused      = 3'd7;

  localparam longint AccHigh = 64'sd549755813887;
  localparam longint AccLow  = -64'sd549755813888;

  // Knee points of the tanh curve, tanh(k/4) in Q1.14.
  localparam int TanhKnee [25] = '{
    0, 4013, 7571, 10406, 12478, 13898, 14830, 15424, 15795,
    16024, 16165, 16250, 16303, 16335, 16354, 16366, 16373,
    16377, 16380, 16382, 16383, 16383, 16383, 16384, 16384
  };

  typedef struct packed {
    op_t                op;
    logic [14:0]        address;
    logic signed [15:0] value;
    logic               last;
  } beat_t;

  logic clk;
  logic rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [6:0] cfg_wdata;

  mlpfr_in_if  in_beat_if ();
  mlpfr_out_if out_beat_if ();

  mlp_forward_relu_tanh_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat_if),
    .out_beat (out_beat_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the network state. Memory contents change only when a
  // beat is accepted; the written flags are set as soon as a beat is queued
  // so that the stimulus never starts an evaluation that reads a hole.
  logic signed [15:0] weight_shadow [NumWeights];
  logic signed [15:0] bias_shadow [NumBiases];
  logic signed [15:0] vector_shadow [NumInputs];
  bit weight_loaded [NumWeights];
  bit bias_loaded [NumBiases];
  bit vector_loaded [NumInputs];

  logic [2:0] layer_count_shadow;
  logic [6:0] width_shadow [4];

  beat_t              beat_queue [$];
  logic signed [15:0] pending_scores [$];
  int                 beats_queued;
  int                 mismatches;
  int                 burst_left;
  int                 gap_left;
  int                 stall_mode;
  int                 cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Saturating add into the 40-bit accumulator.
  function automatic longint sat_acc(longint acc, longint term);
    longint s;
    s = acc + term;
    if (s > AccHigh) s = AccHigh;
    if (s < AccLow) s = AccLow;
    return s;
  endfunction

  function automatic logic signed [15:0] relu_q88(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < 0) return 16'sd0;
    return v[15:0];
  endfunction

  function automatic int width_in_use(int layer);
    int w;
    w = width_shadow[layer];
    if (w == 0) w = 1;
    if (w > NumNeurons) w = NumNeurons;
    return w;
  endfunction

  function automatic int layers_in_use();
    int n;
    n = layer_count_shadow;
    if (n == 0) n = 1;
    if (n > NumLayers) n = NumLayers;
    return n;
  endfunction

  // Interpolated tanh of a non-negative Q8.8 activation, giving Q1.14.
  function automatic logic signed [15:0] tanh_score(logic signed [15:0] x);
    int seg;
    int frac;
    int d;
    if (x <= 0) return 16'sd0;
    seg  = int'(x) >>> 6;
    frac = int'(x) & 63;
    if (seg >= 24) return 16'sd16384;
    d = TanhKnee[seg + 1] - TanhKnee[seg];
    return 16'(TanhKnee[seg] + ((d * frac + 32) >>> 6));
  endfunction

  // Full forward pass over the shadow memories.
  function automatic logic signed [15:0] predict_score();
    logic signed [15:0] act [2][NumNeurons];
    longint acc;
    int cur;
    int prev_w;
    int n;
    int base;
    cur = 0;
    n = width_in_use(0);
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < NumInputs; j++)
        acc = sat_acc(acc, longint'(vector_shadow[j]) *
                           longint'(weight_shadow[(i * NumInputs + j) % NumWeights]));
      acc = sat_acc(acc, longint'(bias_shadow[i]));
      act[0][i] = relu_q88(acc);
    end
    prev_w = n;
    for (int lyr = 1; lyr < layers_in_use(); lyr++) begin
      base = HiddenBase + (lyr - 1) * NumNeurons * NumNeurons;
      n = width_in_use(lyr);
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < prev_w; j++)
          acc = sat_acc(acc, longint'(act[cur][j]) *
                             longint'(weight_shadow[(base + i * NumNeurons + j) % NumWeights]));
        acc = sat_acc(acc, longint'(bias_shadow[lyr * NumNeurons + i]) * 256);
        act[cur ^ 1][i] = relu_q88(acc >>> 8);
      end
      prev_w = n;
      cur = cur ^ 1;
    end
    return tanh_score(act[cur][0]);
  endfunction

  // Update the shadow state with one accepted beat and record any score.
  task automatic absorb_beat(beat_t b);
    case (b.op)
      OP_WEIGHT: weight_shadow[b.address] = b.value;
      OP_BIAS: if (b.address < NumBiases) bias_shadow[b.address] = b.value;
      OP_INPUT: begin
        if (b.address < NumInputs) vector_shadow[b.address] = b.value;
        if (b.last) pending_scores.push_back(predict_score());
      end
      default: ;
    endcase
  endtask

  task automatic queue_beat(op_t op, int address, int value, bit last);
    beat_t b;
    b.op      = op;
    b.address = address[14:0];
    b.value   = value[15:0];
    b.last    = last;
    if (op == OP_WEIGHT) weight_loaded[b.address] = 1'b1;
    if (op == OP_BIAS && b.address < NumBiases) bias_loaded[b.address] = 1'b1;
    if (op == OP_INPUT && b.address < NumInputs) vector_loaded[b.address] = 1'b1;
    beat_queue.push_back(b);
    beats_queued++;
  endtask

  // Mostly small magnitudes keep the sums inside the interesting part of
  // the tanh curve; now and then a full-range value forces saturation.
  function automatic int fill_value();
    if ($urandom_range(0, 15) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 96)) - 40;
  endfunction

  // Load every entry that the current configuration will read but that
  // has never been written.
  task automatic load_missing();
    int n;
    int prev_w;
    int base;
    for (int j = 0; j < NumInputs; j++)
      if (!vector_loaded[j]) queue_beat(OP_INPUT, j, int'($urandom_range(0, 8)) - 3, 1'b0);
    n = width_in_use(0);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < NumInputs; j++)
        if (!weight_loaded[i * NumInputs + j])
          queue_beat(OP_WEIGHT, i * NumInputs + j, fill_value(), 1'b0);
      if (!bias_loaded[i]) queue_beat(OP_BIAS, i, fill_value(), 1'b0);
    end
    prev_w = n;
    for (int lyr = 1; lyr < layers_in_use(); lyr++) begin
      base = HiddenBase + (lyr - 1) * NumNeurons * NumNeurons;
      n = width_in_use(lyr);
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < prev_w; j++)
          if (!weight_loaded[base + i * NumNeurons + j])
            queue_beat(OP_WEIGHT, base + i * NumNeurons + j, fill_value() * 4, 1'b0);
        if (!bias_loaded[lyr * NumNeurons + i])
          queue_beat(OP_BIAS, lyr * NumNeurons + i, fill_value(), 1'b0);
      end
      prev_w = n;
    end
  endtask

  // Start an evaluation with a final element, after filling any holes.
  task automatic run_network(int address, int value);
    load_missing();
    queue_beat(OP_INPUT, address, value, 1'b1);
  endtask

  // Wait until every queued beat is taken and every score has come back,
  // then let the block settle before returning.
  task automatic wait_idle();
    while (beat_queue.size() != 0 || in_beat_if.valid || pending_scores.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(logic [2:0] index, logic [6:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      REG_LAYER_COUNT: layer_count_shadow = data[2:0];
      REG_WIDTH0: width_shadow[0] = data;
      REG_WIDTH1: width_shadow[1] = data;
      REG_WIDTH2: width_shadow[2] = data;
      REG_WIDTH3: width_shadow[3] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_shape(int layers, int w0, int w1, int w2, int w3);
    write_reg(REG_LAYER_COUNT, 7'(layers));
    write_reg(REG_WIDTH0, 7'(w0));
    write_reg(REG_WIDTH1, 7'(w1));
    write_reg(REG_WIDTH2, 7'(w2));
    write_reg(REG_WIDTH3, 7'(w3));
  endtask

  // Input driver. It moves one beat per handshake, works in bursts of
  // random length, and only touches valid once per clock edge. The beat
  // being accepted at an edge is absorbed into the shadow state there.
  always @(posedge clk) begin
    beat_t b;
    if (!rst_n) begin
      in_beat_if.valid <= 1'b0;
    end else begin
      if (in_beat_if.valid && in_beat_if.ready) begin
        b.op      = op_t'(in_beat_if.op);
        b.address = in_beat_if.address;
        b.value   = in_beat_if.value;
        b.last    = in_beat_if.last;
        absorb_beat(b);
      end
      if (!in_beat_if.valid || in_beat_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_beat_if.valid <= 1'b0;
        end else if (beat_queue.size() != 0) begin
          b = beat_queue.pop_front();
          in_beat_if.op      <= b.op;
          in_beat_if.address <= b.address;
          in_beat_if.value   <= b.value;
          in_beat_if.last    <= b.last;
          in_beat_if.valid   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_beat_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready follows a stall pattern whose density is redrawn
  // periodically; mode zero is a stretch with no stalls at all.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 151 == 0) stall_mode = $urandom_range(0, 3);
    if (stall_mode == 0) out_beat_if.ready <= 1'b1;
    else out_beat_if.ready <= ($urandom_range(0, 3) >= stall_mode);
  end

  // Every score beat is compared with the oldest prediction.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_beat_if.valid && out_beat_if.ready) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected score beat: actual %0d", out_beat_if.score);
      end else begin
        want = pending_scores.pop_front();
        if (out_beat_if.score !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Score mismatch: expected %0d, actual %0d", want, out_beat_if.score);
        end
      end
    end
  end

  // Memory operations, the unused op and the ignored last flag, plus the
  // saturating extremes of a single-neuron network.
  task automatic test_directed();
    write_shape(1, 1, 1, 1, 1);
    run_network(0, 1);
    queue_beat(OP_WEIGHT, 0, 32767, 1'b0);
    queue_beat(OP_INPUT, 0, 32767, 1'b1);
    queue_beat(OP_INPUT, 0, -32768, 1'b1);
    queue_beat(OP_WEIGHT, 0, 256, 1'b0);
    queue_beat(OP_BIAS, 0, 300, 1'b0);
    queue_beat(OP_INPUT, 0, 2, 1'b1);
    queue_beat(OP_WEIGHT, 32767, -32768, 1'b1);
    queue_beat(OP_BIAS, 0, -32768, 1'b1);
    queue_beat(OP_BIAS, 32767, 32767, 1'b0);
    queue_beat(OP_BIAS, NumBiases, 1000, 1'b0);
    queue_beat(OP_NONE, 0, 32767, 1'b1);
    queue_beat(OP_NONE, 32767, -1, 1'b0);
    queue_beat(OP_INPUT, 32767, 32767, 1'b1);
    queue_beat(OP_INPUT, NumInputs, -1, 1'b1);
    queue_beat(OP_BIAS, 0, 32767, 1'b0);
    queue_beat(OP_INPUT, 5, 0, 1'b1);
    queue_beat(OP_BIAS, 0, 40, 1'b0);
    queue_beat(OP_INPUT, 0, 1, 1'b1);
  endtask

  // Out-of-range layer count and widths that clamp, with a full-width middle
  // layer, then unused register indexes, zero widths and a short network.
  task automatic test_config_extremes();
    write_shape(7, 1, 127, 1, 2);
    run_network(3, 1);
    run_network(200, -2);
    write_reg(RegUnused, 7'd0);
    write_reg(RegFirstUnused, 7'd127);
    write_shape(4, 1, 64, 2, 1);
    run_network(0, 0);
    write_shape(0, 0, 0, 0, 0);
    run_network(1, 4);
    write_shape(4, 1, 1, 1, 1);
    run_network(2, -1);
    write_shape(2, 0, 127, 0, 127);
    run_network(7, 3);
  endtask

  // Random traffic: mostly weight and input loads into the live region
  // followed by evaluations, with stray addresses and unused ops as noise.
  task automatic test_random();
    int stop_at;
    int pick;
    int addr;
    stop_at = beats_queued + RandomBeats;
    while (beats_queued < stop_at) begin
      if ($urandom_range(0, 199) == 0) begin
        write_shape($urandom_range(0, 7), $urandom_range(0, 2), $urandom_range(0, 8),
                    $urandom_range(0, 5), ($urandom_range(0, 9) == 0) ? 127 :
                    $urandom_range(1, 4));
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 3) == 0) addr = $urandom_range(0, NumWeights - 1);
        else if ($urandom_range(0, 1) == 0) addr = $urandom_range(0, 3 * NumInputs);
        else addr = HiddenBase + $urandom_range(0, 3 * NumNeurons * NumNeurons - 1);
        queue_beat(OP_WEIGHT, addr, fill_value(), $urandom_range(0, 7) == 0);
      end else if (pick < 45) begin
        addr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) :
                                             $urandom_range(0, NumBiases - 1);
        queue_beat(OP_BIAS, addr, fill_value(), $urandom_range(0, 7) == 0);
      end else if (pick < 88) begin
        addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) :
                                             $urandom_range(0, NumInputs - 1);
        queue_beat(OP_INPUT, addr, int'($urandom_range(0, 65535)) - 32768 >>>
                   $urandom_range(0, 15), 1'b0);
      end else if (pick < 96) begin
        run_network($urandom_range(0, 32767), int'($urandom_range(0, 12)) - 4);
      end else begin
        queue_beat(OP_NONE, $urandom_range(0, 32767), int'($urandom_range(0, 65535)),
                   $urandom_range(0, 1));
      end
      if (beat_queue.size() > 64) begin
        while (beat_queue.size() > 8) @(posedge clk);
      end
      if ($urandom_range(0, 299) == 0) wait_idle();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_LAYER_COUNT;
    cfg_wdata          = 7'd0;
    in_beat_if.valid   = 1'b0;
    in_beat_if.op      = OP_NONE;
    in_beat_if.address = 15'd0;
    in_beat_if.value   = 16'sd0;
    in_beat_if.last    = 1'b0;
    out_beat_if.ready  = 1'b0;
    layer_count_shadow = 3'd1;
    for (int k = 0; k < 4; k++) width_shadow[k] = 7'd1;
    beats_queued = 0;
    mismatches   = 0;
    burst_left   = 4;
    gap_left     = 0;
    stall_mode   = 0;
    cycle_count  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random();

    // Drain: every prediction must be matched before the verdict.
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
